>>> rtl/wfpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfpa_pkg: shared definitions for the worst-fit partition allocator
// Default sizes, operation and status codes, register indexes and the
// control group that drives the partition store.
// ----------------------------------------------------------------------------
package wfpa_pkg;

    localparam int DEF_MAX_PARTITIONS = 64;
    localparam int DEF_SIZE_BITS      = 16;

    localparam int OP_BITS      = 2;
    localparam int ST_BITS      = 2;
    localparam int CFG_IDX_BITS = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MEMORY_SIZE     = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_PARTITION_COUNT = CFG_IDX_BITS'(1);

    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    typedef enum logic [ST_BITS-1:0] {
        ST_ALLOC   = 2'd0,
        ST_FRAG    = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_DONE    = 2'd3
    } status_t;

    // Strobes towards the partition store
    typedef struct packed {
        logic rd_en;
        logic size_we;
        logic used_we;
        logic used_data;
    } mem_ctrl_t;

endpackage : wfpa_pkg
`default_nettype wire

>>> rtl/worst_fit_partition_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator: fixed-partition worst-fit allocator
// Loads partition sizes, serves allocation requests from the largest free
// partition that fits, and keeps internal and external fragmentation totals.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  --------  ---------  ------------------------------------------------------
//  s_*       in         tuser: opcode; tdata: part_index, amount
//  m_*       out        tuser: status; tdata: chosen_partition, internal_waste,
//                       internal_total, external_total
//  cfg_*     in         register write: 0 memory_size, 1 partition_count
//
//  Sequencing: a load or no-op passes from idle through the execute and emit
//  states into the output register, and the engine then returns to idle for
//  the next beat, so it takes no new beat before it is through with the last.
//  An allocation scans the active partitions through the single read port of
//  the partition memory, one entry a cycle. A restart sweeps every used mark.
//  Reset: after rst_n rises every used mark is cleared, during which
//  s_tready stays low; partition sizes are not cleared.
//  Stalls: one output register holds a finished result while the next beat
//  is accepted; the engine waits in its result state only while that
//  register is full and m_tready is low.
//
module worst_fit_partition_allocator #(
    parameter  int MAX_PARTITIONS = wfpa_pkg::DEF_MAX_PARTITIONS,
    parameter  int SIZE_BITS      = wfpa_pkg::DEF_SIZE_BITS,
    localparam int IDX_BITS       = $clog2(MAX_PARTITIONS),
    localparam int CNT_BITS       = $clog2(MAX_PARTITIONS + 1),
    localparam int CFG_BITS       = (SIZE_BITS > CNT_BITS) ? SIZE_BITS : CNT_BITS,
    localparam int IN_BITS        = IDX_BITS + SIZE_BITS,
    localparam int IN_TDATA_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS       = IDX_BITS + 3 * SIZE_BITS,
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]             s_tdata,   // part_index, amount
    input  wire logic [wfpa_pkg::OP_BITS-1:0]      s_tuser,   // opcode
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [OUT_TDATA_W-1:0]            m_tdata,   // chosen_partition,
                                                              // internal_waste,
                                                              // internal_total,
                                                              // external_total
    output logic      [wfpa_pkg::ST_BITS-1:0]      m_tuser,   // status
    // Configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [wfpa_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]               cfg_data
);
    import wfpa_pkg::*;

    // Configuration registers; the user must write them only while the block is idle (not enforced here)
    logic [SIZE_BITS-1:0]  memory_size_reg;
    logic [CNT_BITS-1:0]   partition_count_reg;

    // Output register: holds a result beat until the sink takes it
    logic                    out_valid_reg,  out_valid_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg,   out_data_next;
    logic [ST_BITS-1:0]      out_user_reg,   out_user_next;

    // Engine to store
    mem_ctrl_t             mem_ctrl;
    logic [IDX_BITS-1:0]   mem_rd_addr;
    logic [IDX_BITS-1:0]   mem_wr_addr;
    logic [SIZE_BITS-1:0]  mem_wr_size;
    logic [SIZE_BITS-1:0]  mem_rd_size;
    logic                  mem_rd_used;

    // Engine results
    logic                  res_ready;
    logic                  res_valid;
    logic [ST_BITS-1:0]    res_status;
    logic [IDX_BITS-1:0]   res_chosen;
    logic [SIZE_BITS-1:0]  res_waste;
    logic [SIZE_BITS-1:0]  res_internal;
    logic [SIZE_BITS-1:0]  res_external;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_size_reg     <= '0;
            partition_count_reg <= CNT_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MEMORY_SIZE:
                begin
                    memory_size_reg <= cfg_data[SIZE_BITS-1:0];
                end
                REG_PARTITION_COUNT:
                begin
                    partition_count_reg <= cfg_data[CNT_BITS-1:0];
                end
            endcase
        end
    end

    wfpa_store #(
        .DEPTH     (MAX_PARTITIONS),
        .SIZE_BITS (SIZE_BITS)
    ) u_store (
        .clk     (clk),
        .ctrl    (mem_ctrl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_size (mem_wr_size),
        .rd_size (mem_rd_size),
        .rd_used (mem_rd_used)
    );

    wfpa_engine #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .memory_size     (memory_size_reg),
        .partition_count (partition_count_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_opcode       (s_tuser),
        .in_index        (s_tdata[IDX_BITS-1:0]),
        .in_amount       (s_tdata[IDX_BITS +: SIZE_BITS]),
        .mem_ctrl        (mem_ctrl),
        .mem_rd_addr     (mem_rd_addr),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_size     (mem_wr_size),
        .mem_rd_size     (mem_rd_size),
        .mem_rd_used     (mem_rd_used),
        .res_ready       (res_ready),
        .res_valid       (res_valid),
        .res_status      (res_status),
        .res_chosen      (res_chosen),
        .res_waste       (res_waste),
        .res_internal    (res_internal),
        .res_external    (res_external)
    );

    // Room for a new result when the register is empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_TDATA_W'({res_external, res_internal, res_waste, res_chosen});
            out_user_next  = res_status;
        end
        else if (m_tready)
        begin
            // Drop the beat once the sink has taken it
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_user_reg  <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule : worst_fit_partition_allocator
`default_nettype wire

>>> rtl/wfpa_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfpa_store: partition size and used-mark memories
// Two synchronous memories sharing one write address and one read address,
// read data registered.
// ----------------------------------------------------------------------------
module wfpa_store #(
    parameter  int DEPTH     = 64,
    parameter  int SIZE_BITS = 16,
    localparam int IDX_BITS  = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire wfpa_pkg::mem_ctrl_t   ctrl,
    input  wire logic [IDX_BITS-1:0]   rd_addr,
    input  wire logic [IDX_BITS-1:0]   wr_addr,
    input  wire logic [SIZE_BITS-1:0]  wr_size,
    output logic      [SIZE_BITS-1:0]  rd_size,
    output logic                       rd_used
);
    import wfpa_pkg::*;

    logic [SIZE_BITS-1:0] size_mem [DEPTH];
    logic                 used_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.size_we)
        begin
            size_mem[wr_addr] <= wr_size;
        end
        if (ctrl.rd_en)
        begin
            rd_size <= size_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.used_we)
        begin
            used_mem[wr_addr] <= ctrl.used_data;
        end
        if (ctrl.rd_en)
        begin
            rd_used <= used_mem[rd_addr];
        end
    end

endmodule : wfpa_store
`default_nettype wire

>>> rtl/wfpa_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfpa_engine: operation sequencer
// Runs loads, worst-fit scans, restarts and the used-mark clearing sweep;
// holds the running totals.
// ----------------------------------------------------------------------------
module wfpa_engine #(
    parameter  int MAX_PARTITIONS = 64,
    parameter  int SIZE_BITS      = 16,
    localparam int IDX_BITS       = $clog2(MAX_PARTITIONS),
    localparam int CNT_BITS       = $clog2(MAX_PARTITIONS + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [SIZE_BITS-1:0]          memory_size,
    input  wire logic [CNT_BITS-1:0]           partition_count,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [wfpa_pkg::OP_BITS-1:0]  in_opcode,
    input  wire logic [IDX_BITS-1:0]           in_index,
    input  wire logic [SIZE_BITS-1:0]          in_amount,
    output wfpa_pkg::mem_ctrl_t                mem_ctrl,
    output logic      [IDX_BITS-1:0]           mem_rd_addr,
    output logic      [IDX_BITS-1:0]           mem_wr_addr,
    output logic      [SIZE_BITS-1:0]          mem_wr_size,
    input  wire logic [SIZE_BITS-1:0]          mem_rd_size,
    input  wire logic                          mem_rd_used,
    input  wire logic                          res_ready,
    output logic                               res_valid,
    output logic      [wfpa_pkg::ST_BITS-1:0]  res_status,
    output logic      [IDX_BITS-1:0]           res_chosen,
    output logic      [SIZE_BITS-1:0]          res_waste,
    output logic      [SIZE_BITS-1:0]          res_internal,
    output logic      [SIZE_BITS-1:0]          res_external
);
    import wfpa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t                state_reg,      state_next;
    opcode_t               op_reg,         op_next;
    logic [IDX_BITS-1:0]   idx_reg,        idx_next;
    logic [SIZE_BITS-1:0]  amount_reg,     amount_next;
    logic [IDX_BITS-1:0]   last_reg,       last_next;
    logic [SIZE_BITS-1:0]  rem_reg,        rem_next;
    logic [IDX_BITS-1:0]   clr_reg,        clr_next;
    logic                  restart_reg,    restart_next;
    logic [IDX_BITS-1:0]   issue_reg,      issue_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  pipe_valid_reg, pipe_valid_next;
    logic [IDX_BITS-1:0]   pipe_idx_reg,   pipe_idx_next;
    logic                  found_reg,      found_next;
    logic [IDX_BITS-1:0]   best_idx_reg,   best_idx_next;
    logic [SIZE_BITS-1:0]  best_size_reg,  best_size_next;
    logic [SIZE_BITS-1:0]  free_sum_reg,   free_sum_next;
    logic [SIZE_BITS:0]    loaded_sum_reg, loaded_sum_next;
    logic [SIZE_BITS:0]    used_total_reg, used_total_next;
    logic [SIZE_BITS-1:0]  internal_reg,   internal_next;
    logic [SIZE_BITS-1:0]  external_reg,   external_next;
    status_t               status_reg,     status_next;
    logic [IDX_BITS-1:0]   chosen_reg,     chosen_next;
    logic [SIZE_BITS-1:0]  waste_reg,      waste_next;

    // Effective partition count and derived figures
    logic [CNT_BITS-1:0]   count_eff;
    logic [CNT_BITS-1:0]   count_m1;
    logic [IDX_BITS-1:0]   last_idx;
    logic [SIZE_BITS:0]    ms_w;
    logic [SIZE_BITS:0]    rem_w;
    logic [SIZE_BITS-1:0]  scan_size;
    logic                  scan_fits;
    logic [SIZE_BITS:0]    free_add;
    logic [SIZE_BITS-1:0]  free_sat;
    logic [SIZE_BITS-1:0]  waste_calc;
    logic [SIZE_BITS:0]    int_add;
    logic [SIZE_BITS-1:0]  int_sat;
    logic [SIZE_BITS+1:0]  used_add;
    logic [SIZE_BITS:0]    used_sat;
    logic [SIZE_BITS-1:0]  ext_dec;
    logic                  avail_ok;
    logic [SIZE_BITS+1:0]  load_add;
    logic [SIZE_BITS:0]    load_sat;

    always_comb
    begin
        if (partition_count == '0)
        begin
            count_eff = CNT_BITS'(1);
        end
        else if (partition_count > CNT_BITS'(MAX_PARTITIONS))
        begin
            count_eff = CNT_BITS'(MAX_PARTITIONS);
        end
        else
        begin
            count_eff = partition_count;
        end
    end

    assign count_m1 = count_eff - CNT_BITS'(1);
    assign last_idx = count_m1[IDX_BITS-1:0];

    assign ms_w  = {1'b0, memory_size};
    assign rem_w = (ms_w > loaded_sum_reg) ? (ms_w - loaded_sum_reg) : '0;

    // Last partition takes the remainder, never the stored size
    assign scan_size = (pipe_idx_reg == last_reg) ? rem_reg : mem_rd_size;
    assign scan_fits = !mem_rd_used && (scan_size >= amount_reg)
                       && (!found_reg || (scan_size >= best_size_reg));

    assign free_add = {1'b0, free_sum_reg} + {1'b0, (mem_rd_used ? '0 : scan_size)};
    assign free_sat = free_add[SIZE_BITS] ? '1 : free_add[SIZE_BITS-1:0];

    assign waste_calc = best_size_reg - amount_reg;
    assign int_add    = {1'b0, internal_reg} + {1'b0, waste_calc};
    assign int_sat    = int_add[SIZE_BITS] ? '1 : int_add[SIZE_BITS-1:0];
    assign used_add   = {1'b0, used_total_reg} + (SIZE_BITS+2)'(best_size_reg);
    assign used_sat   = used_add[SIZE_BITS+1] ? '1 : used_add[SIZE_BITS:0];
    assign ext_dec    = (external_reg > best_size_reg) ? (external_reg - best_size_reg) : '0;
    assign avail_ok   = (ms_w > used_total_reg)
                        && ((ms_w - used_total_reg) > {1'b0, amount_reg});
    assign load_add   = {1'b0, loaded_sum_reg} + (SIZE_BITS+2)'(amount_reg);
    assign load_sat   = load_add[SIZE_BITS+1] ? '1 : load_add[SIZE_BITS:0];

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        amount_next     = amount_reg;
        last_next       = last_reg;
        rem_next        = rem_reg;
        clr_next        = clr_reg;
        restart_next    = restart_reg;
        issue_next      = issue_reg;
        issue_done_next = issue_done_reg;
        pipe_valid_next = pipe_valid_reg;
        pipe_idx_next   = pipe_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_size_next  = best_size_reg;
        free_sum_next   = free_sum_reg;
        loaded_sum_next = loaded_sum_reg;
        used_total_next = used_total_reg;
        internal_next   = internal_reg;
        external_next   = external_reg;
        status_next     = status_reg;
        chosen_next     = chosen_reg;
        waste_next      = waste_reg;

        mem_ctrl    = '0;
        mem_rd_addr = issue_reg;
        mem_wr_addr = idx_reg;
        mem_wr_size = amount_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the used marks, one entry a cycle
                mem_ctrl.used_we   = 1'b1;
                mem_ctrl.used_data = 1'b0;
                mem_wr_addr        = clr_reg;
                if (clr_reg == IDX_BITS'(MAX_PARTITIONS - 1))
                begin
                    if (restart_reg)
                    begin
                        restart_next = 1'b0;
                        status_next  = ST_DONE;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    clr_next = clr_reg + IDX_BITS'(1);
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = opcode_t'(in_opcode);
                    idx_next    = in_index;
                    amount_next = in_amount;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                last_next   = last_idx;
                rem_next    = rem_w[SIZE_BITS-1:0];
                status_next = ST_DONE;
                chosen_next = '0;
                waste_next  = '0;
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        if (idx_reg < last_idx)
                        begin
                            mem_ctrl.size_we   = 1'b1;
                            mem_ctrl.used_we   = 1'b1;
                            mem_ctrl.used_data = 1'b0;
                            loaded_sum_next    = load_sat;
                        end
                        state_next = S_EMIT;
                    end
                    OP_ALLOC:
                    begin
                        issue_next      = '0;
                        issue_done_next = 1'b0;
                        pipe_valid_next = 1'b0;
                        found_next      = 1'b0;
                        best_idx_next   = '0;
                        best_size_next  = '0;
                        free_sum_next   = '0;
                        state_next      = S_SCAN;
                    end
                    OP_RESTART:
                    begin
                        used_total_next = '0;
                        internal_next   = '0;
                        external_next   = '0;
                        clr_next        = '0;
                        restart_next    = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    OP_NOP:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_SCAN:
            begin
                // Issue one read a cycle; evaluate the entry read last cycle
                if (!issue_done_reg)
                begin
                    mem_ctrl.rd_en  = 1'b1;
                    pipe_valid_next = 1'b1;
                    pipe_idx_next   = issue_reg;
                    if (issue_reg == last_reg)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        issue_next = issue_reg + IDX_BITS'(1);
                    end
                end
                else
                begin
                    pipe_valid_next = 1'b0;
                end

                if (pipe_valid_reg)
                begin
                    if (scan_fits)
                    begin
                        found_next     = 1'b1;
                        best_idx_next  = pipe_idx_reg;
                        best_size_next = scan_size;
                    end
                    free_sum_next = free_sat;
                    if (pipe_idx_reg == last_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                if (found_reg)
                begin
                    mem_ctrl.used_we   = 1'b1;
                    mem_ctrl.used_data = 1'b1;
                    mem_wr_addr        = best_idx_reg;
                    status_next        = ST_ALLOC;
                    chosen_next        = best_idx_reg;
                    waste_next         = waste_calc;
                    internal_next      = int_sat;
                    used_total_next    = used_sat;
                    if (external_reg != '0)
                    begin
                        external_next = ext_dec;
                    end
                end
                else if (avail_ok)
                begin
                    status_next   = ST_FRAG;
                    external_next = free_sum_reg;
                end
                else
                begin
                    status_next = ST_NOSPACE;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                res_valid = res_ready;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            op_reg         <= OP_NOP;
            idx_reg        <= '0;
            amount_reg     <= '0;
            last_reg       <= '0;
            rem_reg        <= '0;
            clr_reg        <= '0;
            restart_reg    <= 1'b0;
            issue_reg      <= '0;
            issue_done_reg <= 1'b0;
            pipe_valid_reg <= 1'b0;
            pipe_idx_reg   <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_size_reg  <= '0;
            free_sum_reg   <= '0;
            loaded_sum_reg <= '0;
            used_total_reg <= '0;
            internal_reg   <= '0;
            external_reg   <= '0;
            status_reg     <= ST_DONE;
            chosen_reg     <= '0;
            waste_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            idx_reg        <= idx_next;
            amount_reg     <= amount_next;
            last_reg       <= last_next;
            rem_reg        <= rem_next;
            clr_reg        <= clr_next;
            restart_reg    <= restart_next;
            issue_reg      <= issue_next;
            issue_done_reg <= issue_done_next;
            pipe_valid_reg <= pipe_valid_next;
            pipe_idx_reg   <= pipe_idx_next;
            found_reg      <= found_next;
            best_idx_reg   <= best_idx_next;
            best_size_reg  <= best_size_next;
            free_sum_reg   <= free_sum_next;
            loaded_sum_reg <= loaded_sum_next;
            used_total_reg <= used_total_next;
            internal_reg   <= internal_next;
            external_reg   <= external_next;
            status_reg     <= status_next;
            chosen_reg     <= chosen_next;
            waste_reg      <= waste_next;
        end
    end

    assign res_status   = status_reg;
    assign res_chosen   = chosen_reg;
    assign res_waste    = waste_reg;
    assign res_internal = internal_reg;
    assign res_external = external_reg;

    // Reads and writes of the store never share a cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctrl.rd_en |-> !(mem_ctrl.size_we || mem_ctrl.used_we))
        else $error("store read and write in the same cycle");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && found_reg) |-> (best_idx_reg <= last_reg))
        else $error("chosen partition beyond the active count");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && pipe_valid_reg && pipe_idx_reg == last_reg)
        |=> (state_reg == S_DECIDE))
        else $error("scan did not finish on the last entry");

    a_mark_only_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctrl.used_we && mem_ctrl.used_data) |-> (state_reg == S_DECIDE && found_reg))
        else $error("used mark set outside an allocation");

    a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (state_reg == S_IDLE))
        else $error("engine did not return to idle after a result");

endmodule : wfpa_engine
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the worst-fit partition allocator
// Streams load, allocate, restart and no-op beats into the block under
// changing memory sizes and partition counts, predicts every result beat
// from a behavioural copy of the allocator, and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;

    import wfpa_pkg::*;

    localparam int NPART    = DEF_MAX_PARTITIONS;
    localparam int SZ_MAX   = (1 << DEF_SIZE_BITS) - 1;
    localparam int WIDE_MAX = (1 << (DEF_SIZE_BITS + 1)) - 1;
    localparam int N_PHASES = 9;
    localparam int PHASE_ITEMS = 140;

    // One request beat as the sender presents it
    typedef struct {
        opcode_t     op;
        logic [5:0]  idx;
        logic [15:0] amount;
    } alloc_req_t;

    // One result beat as the allocator should return it
    typedef struct {
        logic [1:0]  status;
        logic [5:0]  part;
        logic [15:0] waste;
        logic [15:0] waste_sum;
        logic [15:0] frag;
    } alloc_outcome_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [5:0] part_index, [21:6] amount
    logic [1:0]  s_tuser   = '0;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;          // [5:0] chosen_partition, [21:6] internal_waste,
                                   // [37:22] internal_total, [53:38] external_total
    logic [1:0]  m_tuser;          // [1:0] status
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Beats waiting to be sent, and results still owed by the block
    alloc_req_t     request_q[$];
    alloc_outcome_t outcome_q[$];

    // Behavioural copy of the allocator state and its registers
    logic [15:0] mem_size_r   = '0;
    logic [6:0]  part_count_r = 7'd1;
    logic [15:0] part_size[NPART];
    bit          part_used[NPART];
    logic [16:0] loaded_sum   = '0;
    logic [16:0] used_memory  = '0;
    logic [15:0] internal_sum = '0;
    logic [15:0] external_frag = '0;

    // Sizes the stimulus believes it has loaded; used only to aim requests
    int plan_size[NPART];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  beat_taken    = 1'b0;
    int  mismatches    = 0;
    int  beats_in      = 0;
    int  n_alloc       = 0;
    int  n_frag        = 0;
    int  n_nospace     = 0;
    int  n_done        = 0;
    int  n_settings    = 0;

    worst_fit_partition_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Allocator prediction
    // ------------------------------------------------------------------------

    function automatic int clip(int value, int limit);
        return (value > limit) ? limit : value;
    endfunction

    // Out-of-range counts fold back: zero acts as one, above the array as full
    function automatic int live_partitions();
        if (part_count_r == 0)
            return 1;
        if (int'(part_count_r) > NPART)
            return NPART;
        return int'(part_count_r);
    endfunction

    // The last live partition holds whatever the loaded sizes leave over
    function automatic int part_capacity(int j, int cnt);
        if (j == cnt - 1)
            return (int'(mem_size_r) > int'(loaded_sum)) ?
                   int'(mem_size_r) - int'(loaded_sum) : 0;
        return int'(part_size[j]);
    endfunction

    function automatic alloc_outcome_t allocate_worst_fit(opcode_t op, logic [5:0] idx,
                                                          logic [15:0] amount);
        alloc_outcome_t r;
        int cnt;
        int best;
        int best_sz;
        int sz;
        int free_sum;
        bit found;
        cnt      = live_partitions();
        r.status = ST_DONE;
        r.part   = '0;
        r.waste  = '0;
        found    = 1'b0;
        best     = 0;
        best_sz  = 0;
        free_sum = 0;
        case (op)
            OP_LOAD:
            begin
                // Loads to the remainder partition or beyond are dropped
                if (int'(idx) + 1 < cnt)
                begin
                    part_size[idx] = amount;
                    part_used[idx] = 1'b0;
                    loaded_sum = 17'(clip(int'(loaded_sum) + int'(amount), WIDE_MAX));
                end
            end
            OP_ALLOC:
            begin
                // Largest free fit wins; >= hands a tie to the higher index
                for (int j = 0; j < cnt; j++)
                begin
                    sz = part_capacity(j, cnt);
                    if (!part_used[j] && sz >= int'(amount) && (!found || sz >= best_sz))
                    begin
                        found   = 1'b1;
                        best    = j;
                        best_sz = sz;
                    end
                end
                if (found)
                begin
                    r.status = ST_ALLOC;
                    r.part   = best[5:0];
                    r.waste  = 16'(best_sz - int'(amount));
                    part_used[best] = 1'b1;
                    internal_sum = 16'(clip(int'(internal_sum) + best_sz - int'(amount),
                                            SZ_MAX));
                    used_memory  = 17'(clip(int'(used_memory) + best_sz, WIDE_MAX));
                    if (external_frag != 0)
                        external_frag = (int'(external_frag) > best_sz) ?
                                        16'(int'(external_frag) - best_sz) : '0;
                end
                else if (int'(mem_size_r) > int'(used_memory) &&
                         int'(mem_size_r) - int'(used_memory) > int'(amount))
                begin
                    // No fit although enough memory is free: refresh the figure
                    r.status = ST_FRAG;
                    for (int j = 0; j < cnt; j++)
                        if (!part_used[j])
                            free_sum = clip(free_sum + part_capacity(j, cnt), SZ_MAX);
                    external_frag = 16'(free_sum);
                end
                else
                begin
                    r.status = ST_NOSPACE;
                end
            end
            OP_RESTART:
            begin
                // Sizes and loaded_sum survive a restart
                for (int j = 0; j < NPART; j++)
                    part_used[j] = 1'b0;
                used_memory   = '0;
                internal_sum  = '0;
                external_frag = '0;
            end
            default:
            begin
            end
        endcase
        r.waste_sum = internal_sum;
        r.frag      = external_frag;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present queued beats at the falling edge, idling at random
    // ------------------------------------------------------------------------

    always @(negedge clk)
    begin : drive_requests
        alloc_req_t nxt;
        bit         holding;
        holding    = s_tvalid && !beat_taken;
        beat_taken = 1'b0;
        if (rst_n && !holding)
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= {2'b00, nxt.amount, nxt.idx};
            end
            else
            begin
                // Idle: drop valid and scribble on the payload
                s_tvalid <= 1'b0;
                s_tuser  <= 2'($urandom);
                s_tdata  <= 24'($urandom);
            end
        end
    end

    always @(negedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted request, check every result beat
    // ------------------------------------------------------------------------

    task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
        mismatches++;
        $error("%s: expected %0d, got %0d", name, want, got);
    endtask

    always @(posedge clk)
    begin : watch_beats
        alloc_outcome_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                outcome_q.push_back(allocate_worst_fit(opcode_t'(s_tuser), s_tdata[5:0],
                                                       s_tdata[21:6]));
                beat_taken = 1'b1;
                beats_in++;
            end
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    $error("result beat with no request outstanding");
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (m_tuser !== want.status)
                        flag_field("status", want.status, m_tuser);
                    if (m_tdata[5:0] !== want.part)
                        flag_field("chosen_partition", want.part, m_tdata[5:0]);
                    if (m_tdata[21:6] !== want.waste)
                        flag_field("internal_waste", want.waste, m_tdata[21:6]);
                    if (m_tdata[37:22] !== want.waste_sum)
                        flag_field("internal_total", want.waste_sum, m_tdata[37:22]);
                    if (m_tdata[53:38] !== want.frag)
                        flag_field("external_total", want.frag, m_tdata[53:38]);
                    case (want.status)
                        ST_ALLOC:   n_alloc++;
                        ST_FRAG:    n_frag++;
                        ST_NOSPACE: n_nospace++;
                        default:    n_done++;
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic push_req(opcode_t op, int idx, int amount);
        alloc_req_t r;
        r.op     = op;
        r.idx    = 6'(idx);
        r.amount = 16'((amount > SZ_MAX) ? SZ_MAX : (amount < 0) ? 0 : amount);
        if (op == OP_LOAD)
            plan_size[r.idx] = int'(r.amount);
        request_q.push_back(r);
    endtask

    // Hold until the block has nothing left in flight, then let it settle
    task automatic wait_quiet(int extra);
        while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == REG_MEMORY_SIZE)
            mem_size_r = value;
        else
            part_count_r = value[6:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_layout(int mem, int cnt);
        write_reg(REG_MEMORY_SIZE, 16'(mem));
        write_reg(REG_PARTITION_COUNT, 16'(cnt));
        n_settings++;
    endtask

    // Load every live sized partition first so no request reads an unset size,
    // then mix aimed requests with reloads, restarts and no-ops
    task automatic queue_random_phase(int mem, int cnt_cfg, int n_items);
        int eff;
        int share;
        int j;
        int base;
        int amt;
        int roll;
        int made;
        eff   = (cnt_cfg == 0) ? 1 : (cnt_cfg > NPART) ? NPART : cnt_cfg;
        share = mem / eff + 1;
        made  = 0;
        for (j = 0; j < eff - 1; j++)
        begin
            amt = (j > 0 && $urandom_range(3) == 0) ? plan_size[j - 1] :
                  $urandom_range(0, share + share / 4);
            push_req(OP_LOAD, j, amt);
            made++;
        end
        while (made < n_items)
        begin
            roll = $urandom_range(99);
            j    = (eff > 1) ? $urandom_range(0, eff - 2) : 0;
            base = (eff > 1) ? plan_size[j] : mem;
            if (roll < 62)
            begin
                case ($urandom_range(9))
                    0, 1, 2: amt = base - $urandom_range(0, (base < 16) ? base : 16);
                    3, 4:    amt = base;
                    5:       amt = base + 1;
                    6:       amt = 0;
                    7:       amt = $urandom_range(0, mem);
                    default: amt = $urandom_range(0, base + base / 2 + 1);
                endcase
                push_req(OP_ALLOC, $urandom_range(0, NPART - 1), amt);
            end
            else if (roll < 80)
            begin
                if ($urandom_range(4) == 0)
                    j = $urandom_range(0, NPART - 1);
                amt = ($urandom_range(49) == 0) ? SZ_MAX : $urandom_range(0, share + share / 4);
                push_req(OP_LOAD, j, amt);
            end
            else if (roll < 86)
                push_req(OP_RESTART, $urandom_range(0, NPART - 1), $urandom_range(0, SZ_MAX));
            else if (roll < 91)
                push_req(OP_NOP, $urandom_range(0, NPART - 1), $urandom_range(0, SZ_MAX));
            else
                push_req(OP_ALLOC, $urandom_range(0, NPART - 1), $urandom_range(0, SZ_MAX));
            made++;
        end
    endtask

    initial
    begin : run_stimulus
        int phase_mem[N_PHASES];
        int phase_cnt[N_PHASES];
        phase_mem = '{4000, 65535, 0, 1200, 30000, 65535, 500, 65535, 9000};
        phase_cnt = '{8, 64, 1, 3, 0, 100, 16, 2, 33};
        for (int j = 0; j < NPART; j++)
        begin
            part_size[j] = '0;
            part_used[j] = 1'b0;
            plan_size[j] = 0;
        end

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset layout: one partition of size zero, so a zero request fits once
        send_idle_pct = 8;
        recv_idle_pct = 52;
        push_req(OP_ALLOC, 0, 0);
        push_req(OP_ALLOC, 0, 0);
        push_req(OP_NOP, 63, SZ_MAX);
        push_req(OP_LOAD, 0, SZ_MAX);
        push_req(OP_RESTART, 0, 0);
        wait_quiet(8);

        // Small hand-checked layout: ties, remainder partition, reload, failures
        set_layout(1000, 4);
        push_req(OP_LOAD, 0, 300);
        push_req(OP_LOAD, 1, 300);
        push_req(OP_LOAD, 2, 200);
        push_req(OP_LOAD, 63, SZ_MAX);
        push_req(OP_LOAD, 3, 12345);
        push_req(OP_ALLOC, 0, 200);
        push_req(OP_ALLOC, 0, 250);
        push_req(OP_ALLOC, 0, 200);
        push_req(OP_ALLOC, 0, 201);
        push_req(OP_ALLOC, 0, 150);
        push_req(OP_ALLOC, 0, 1);
        push_req(OP_RESTART, 0, 0);
        push_req(OP_ALLOC, 0, 350);
        push_req(OP_ALLOC, 0, 300);
        push_req(OP_ALLOC, 0, 0);
        push_req(OP_LOAD, 1, 50);
        push_req(OP_ALLOC, 0, SZ_MAX);
        push_req(OP_ALLOC, 0, 40);
        wait_quiet(8);

        // Random phases; idling shifts from a slow receiver to a slow sender
        // and finally to none. Each boundary stalls the sender until drained.
        for (int p = 0; p < N_PHASES; p++)
        begin
            send_idle_pct = (p < 3) ? 8 : (p < 6) ? 52 : 0;
            recv_idle_pct = (p < 3) ? 52 : (p < 6) ? 8 : 0;
            set_layout(phase_mem[p], phase_cnt[p]);
            queue_random_phase(phase_mem[p], phase_cnt[p], PHASE_ITEMS);
            wait_quiet(8);
        end

        // Saturation tail: full-size partitions drive the internal total and the used and loaded sums to their ceilings
        set_layout(SZ_MAX, 4);
        push_req(OP_LOAD, 0, SZ_MAX);
        push_req(OP_LOAD, 1, SZ_MAX);
        push_req(OP_LOAD, 2, SZ_MAX);
        push_req(OP_ALLOC, 0, 0);
        push_req(OP_ALLOC, 0, 0);
        push_req(OP_ALLOC, 0, 0);
        push_req(OP_ALLOC, 0, 0);
        push_req(OP_ALLOC, 0, 1);
        push_req(OP_RESTART, 0, 0);
        wait_quiet(80);

        $display("covered %0d request beats over %0d register settings",
                 beats_in, n_settings + 1);
        $display("results: %0d allocated, %0d fragmented, %0d no space, %0d other",
                 n_alloc, n_frag, n_nospace, n_done);
        if (mismatches == 0)
            $display("worst_fit_partition_allocator: match");
        else
            $display("worst_fit_partition_allocator: mismatch");
        $finish;
    end

    // Watchdog: ends the run with a mismatch if the stimulus never finishes
    initial
    begin
        #20_000_000;
        $display("worst_fit_partition_allocator: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
rtl/wfpa_pkg.sv
rtl/wfpa_store.sv
rtl/wfpa_engine.sv
rtl/worst_fit_partition_allocator.sv
verif/tb_top.sv
